[src/mpct_pkg.sv]
package mpct_pkg;

  localparam int BYTE_W = 8;
  localparam int BTN_W  = 3;

  localparam logic [BYTE_W-1:0] COLS_RESET = 8'd80;
  localparam logic [BYTE_W-1:0] ROWS_RESET = 8'd25;

  // Configuration register indexes
  localparam logic CFG_SCREEN_COLUMNS = 1'b0;
  localparam logic CFG_SCREEN_ROWS    = 1'b1;

  // Byte slot within a packet; the unused code acts as the first slot
  typedef enum logic [1:0] {
    POS_BUTTON = 2'd0,
    POS_X      = 2'd1,
    POS_Y      = 2'd2
  } pos_t;

  typedef struct packed {
    logic [BTN_W-1:0]  buttons;
    logic [BYTE_W-1:0] x_motion;
    logic [BYTE_W-1:0] y_motion;
  } packet_t;

  typedef struct packed {
    logic [BTN_W-1:0]  button_changes;
    logic [BTN_W-1:0]  button_bits;
    logic [BYTE_W-1:0] cur_row;
    logic [BYTE_W-1:0] cur_col;
    logic [BYTE_W-1:0] prev_row;
    logic [BYTE_W-1:0] prev_col;
  } result_t;

  // v is a 10-bit signed sum; a size of zero behaves like one
  function automatic logic [BYTE_W-1:0] clamp_coord(logic signed [9:0] v,
                                                    logic [BYTE_W-1:0] size);
    logic [BYTE_W-1:0] top;
    logic signed [9:0] top_s;
    top   = (size == '0) ? '0 : size - 8'd1;
    top_s = $signed({2'b00, top});
    if (v < 0) begin
      clamp_coord = '0;
    end else if (v > top_s) begin
      clamp_coord = top;
    end else begin
      clamp_coord = v[BYTE_W-1:0];
    end
  endfunction

endpackage

[src/mpct_assembler.sv]
module mpct_assembler (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic [7:0]              data_byte,
  input  logic                    aux_ready,
  output logic                    complete,
  output mpct_pkg::packet_t       pkt
);
  import mpct_pkg::*;

  pos_t              pos;
  pos_t              pos_next;
  logic [BYTE_W-1:0] held_button_byte;
  logic [BYTE_W-1:0] held_x_motion;

  always_comb begin
    pos_next = pos;
    if (aux_ready) begin
      case (pos)
        POS_X:   pos_next = POS_Y;
        POS_Y:   pos_next = POS_BUTTON;
        default: pos_next = POS_X;
      endcase
    end
  end

  always_comb begin
    complete     = aux_ready && (pos == POS_Y);
    pkt.buttons  = held_button_byte[BTN_W-1:0];
    pkt.x_motion = held_x_motion;
    pkt.y_motion = data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_BUTTON;
    end else if (advance) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && aux_ready) begin
      if (pos == POS_X) begin
        held_x_motion <= data_byte;
      end else if (pos != POS_Y) begin
        held_button_byte <= data_byte;
      end
    end
  end

endmodule

[src/mpct_cursor.sv]
module mpct_cursor (
  input  logic              clk,
  input  logic              rst,
  input  logic              update,
  input  mpct_pkg::packet_t pkt,
  input  logic [7:0]        screen_columns,
  input  logic [7:0]        screen_rows,
  output mpct_pkg::result_t res
);
  import mpct_pkg::*;

  logic [BYTE_W-1:0] cursor_col;
  logic [BYTE_W-1:0] cursor_row;
  logic [BTN_W-1:0]  last_buttons;
  logic signed [9:0] col_sum;
  logic signed [9:0] row_sum;

  // X adds, Y subtracts (device Y grows upward)
  assign col_sum = $signed({2'b00, cursor_col}) + 10'($signed(pkt.x_motion));
  assign row_sum = $signed({2'b00, cursor_row}) - 10'($signed(pkt.y_motion));

  always_comb begin
    res.prev_col       = cursor_col;
    res.prev_row       = cursor_row;
    res.cur_col        = clamp_coord(col_sum, screen_columns);
    res.cur_row        = clamp_coord(row_sum, screen_rows);
    res.button_bits    = pkt.buttons;
    res.button_changes = pkt.buttons ^ last_buttons;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col   <= '0;
      cursor_row   <= '0;
      last_buttons <= '0;
    end else if (update) begin
      cursor_col   <= res.cur_col;
      cursor_row   <= res.cur_row;
      last_buttons <= res.button_bits;
    end
  end

endmodule

[src/mouse_packet_cursor_tracker.sv]
// Path: a packet's third byte passes through the input register, then the
// result register, before m_axis_tvalid rises.
// Throughput: one byte per cycle; the input register frees unless it holds a
// packet's last byte while the result register is full and not being taken.
// Reset (rst, synchronous): packet slot, cursor and buttons go to zero,
// screen size to 80 x 25, both registers empty.
module mouse_packet_cursor_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] aux_ready
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // prev_col, prev_row, cur_col, cur_row,
                                      // button_bits, button_changes, 2'b0
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import mpct_pkg::*;

  logic [BYTE_W-1:0] screen_columns;
  logic [BYTE_W-1:0] screen_rows;

  logic              in_valid;
  logic [BYTE_W-1:0] in_data;
  logic              in_aux;
  logic              in_advance;
  logic              out_load_ok;
  logic              complete;
  packet_t           pkt;
  result_t           res;
  result_t           out_res;

  assign out_load_ok   = !m_axis_tvalid || m_axis_tready;
  assign in_advance    = in_valid && (!complete || out_load_ok);
  assign s_axis_tready = !in_valid || in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_columns <= COLS_RESET;
      screen_rows    <= ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_COLUMNS: screen_columns <= cfg_data;
        CFG_SCREEN_ROWS:    screen_rows    <= cfg_data;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data <= s_axis_tdata;
      in_aux  <= s_axis_tuser;
    end
  end

  mpct_assembler u_assembler (
    .clk       (clk),
    .rst       (rst),
    .advance   (in_advance),
    .data_byte (in_data),
    .aux_ready (in_aux),
    .complete  (complete),
    .pkt       (pkt)
  );

  mpct_cursor u_cursor (
    .clk            (clk),
    .rst            (rst),
    .update         (in_advance && complete),
    .pkt            (pkt),
    .screen_columns (screen_columns),
    .screen_rows    (screen_rows),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load_ok) begin
      m_axis_tvalid <= in_advance && complete;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && complete) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {2'b00, out_res.button_changes, out_res.button_bits,
                         out_res.cur_row, out_res.cur_col,
                         out_res.prev_row, out_res.prev_col};

endmodule

[src/mpct_checker.sv]
module mpct_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  logic       out_fire;
  logic [7:0] seen_col;
  logic [7:0] seen_row;
  logic [2:0] seen_buttons;

  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Last delivered cursor and buttons, as the ports show them
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_col     <= '0;
      seen_row     <= '0;
      seen_buttons <= '0;
    end else if (out_fire) begin
      seen_col     <= m_axis_tdata[23:16];
      seen_row     <= m_axis_tdata[31:24];
      seen_buttons <= m_axis_tdata[34:32];
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_prev_cell: assert property (@(posedge clk) disable iff (rst)
    out_fire |-> m_axis_tdata[7:0] == seen_col && m_axis_tdata[15:8] == seen_row)
    else $error("previous cell differs from last delivered cursor");

  a_button_changes: assert property (@(posedge clk) disable iff (rst)
    out_fire |-> m_axis_tdata[37:35] == (m_axis_tdata[34:32] ^ seen_buttons))
    else $error("button change mask inconsistent");

endmodule

bind mouse_packet_cursor_tracker mpct_checker u_mpct_checker (.*);

[sim/mouse_cursor_checker.sv]
`timescale 1ns / 100ps

module mouse_cursor_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] aux_ready
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // prev_col, prev_row, cur_col, cur_row,
                                      // button_bits, button_changes, 2'b0
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          pending_moves,
  output int          moves_checked
);
  import mpct_pkg::*;

  // zero size behaves like one
  function automatic logic [7:0] clamp_to_screen(int v, logic [7:0] size);
    int top;
    top = (size == 8'd0) ? 0 : int'(size) - 1;
    if (v < 0) return 8'd0;
    if (v > top) return 8'(top);
    return 8'(v);
  endfunction

  result_t          move_q[$];
  pos_t             slot;
  logic [7:0]       held_btn;
  logic [7:0]       held_x;
  logic [7:0]       col;
  logic [7:0]       row;
  logic [7:0]       cols;
  logic [7:0]       rows;
  logic [BTN_W-1:0] last_btn;
  int               errs = 0;
  int               checked = 0;

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      move_q.delete();
      slot     = POS_BUTTON;
      held_btn = '0;
      held_x   = '0;
      col      = '0;
      row      = '0;
      last_btn = '0;
      cols     = COLS_RESET;
      rows     = ROWS_RESET;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[37:0]);
        if (move_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("checker: cursor update with none pending, data %h", m_axis_tdata);
        end else begin
          want = move_q.pop_front();
          checked++;
          if (got !== want) begin
            errs++;
            if (errs <= 10)
              $display({"checker: mismatch exp %0d,%0d->%0d,%0d btn %b chg %b",
                        " got %0d,%0d->%0d,%0d btn %b chg %b"},
                       want.prev_col, want.prev_row, want.cur_col, want.cur_row,
                       want.button_bits, want.button_changes,
                       got.prev_col, got.prev_row, got.cur_col, got.cur_row,
                       got.button_bits, got.button_changes);
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_SCREEN_COLUMNS: cols = cfg_data;
          CFG_SCREEN_ROWS:    rows = cfg_data;
          default: ;
        endcase
      end

      // bytes without aux_ready leave everything untouched
      if (s_axis_tvalid && s_axis_tready && s_axis_tuser) begin
        case (slot)
          POS_X: begin
            held_x = s_axis_tdata;
            slot   = POS_Y;
          end
          POS_Y: begin
            want.prev_col       = col;
            want.prev_row       = row;
            want.cur_col        = clamp_to_screen(int'(col) + int'($signed(held_x)), cols);
            want.cur_row        = clamp_to_screen(int'(row) - int'($signed(s_axis_tdata)),
                                                  rows);
            want.button_bits    = held_btn[BTN_W-1:0];
            want.button_changes = held_btn[BTN_W-1:0] ^ last_btn;
            move_q.push_back(want);
            col      = want.cur_col;
            row      = want.cur_row;
            last_btn = want.button_bits;
            slot     = POS_BUTTON;
          end
          default: begin
            held_btn = s_axis_tdata;
            slot     = POS_X;
          end
        endcase
      end
    end
    mismatches    <= errs;
    pending_moves <= move_q.size();
    moves_checked <= checked;
  end

endmodule

[sim/mouse_packet_cursor_tracker_tb.sv]
`timescale 1ns / 100ps

module mouse_packet_cursor_tracker_tb;
  import mpct_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int AUX_TARGET  = 800;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_SCREEN_COLUMNS;
  logic [7:0]  cfg_data = '0;

  int mismatches;
  int pending_moves;
  int moves_checked;
  int cycles = 0;
  int aux_bytes = 0;
  int ignored_bytes = 0;
  int screen_changes = 0;
  bit idle_on = 1'b1;

  mouse_packet_cursor_tracker dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  mouse_cursor_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending_moves (pending_moves),
    .moves_checked (moves_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stall before each item, tvalid sampled at negedge
  initial begin
    int  gap;
    bit  took;
    while (rst) @(posedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk);
        took = m_axis_tvalid;
        @(posedge clk);
      end while (!took);
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic aux);
    int gap;
    bit took;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= aux;
    do begin
      @(negedge clk);
      took = s_axis_tready;
      @(posedge clk);
    end while (!took);
    if (aux) aux_bytes++;
    else ignored_bytes++;
  endtask

  task automatic send_packet(input logic [7:0] btn, input logic [7:0] dx,
                             input logic [7:0] dy);
    send_byte(btn, 1'b1);
    send_byte(dx, 1'b1);
    send_byte(dy, 1'b1);
  endtask

  // hold off until every cursor update is out, then let the pipe settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_moves != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_screen(input logic [7:0] cols, input logic [7:0] rows);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCREEN_COLUMNS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_index <= CFG_SCREEN_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_we <= 1'b0;
    screen_changes++;
  endtask

  function automatic logic [7:0] pick_size();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd255;
      3: return 8'($urandom_range(2, 8));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_motion();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 16) - 8);
    return 8'($urandom);
  endfunction

  initial begin
    int target;
    int r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default 80 x 25 screen, cursor at the corner
    send_byte(8'h5A, 1'b0);
    send_packet(8'hFF, 8'h7F, 8'h80);       // clamp to far corner, high button bits
    send_byte(8'h00, 1'b1);
    send_byte(8'hA5, 1'b0);                 // ignored inside a packet
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b1);                 // back below zero on both axes
    send_packet(8'hF8, 8'h05, 8'hFB);
    send_packet(8'h02, 8'h00, 8'h00);
    wait_idle();
    set_screen(8'd0, 8'd0);                 // zero size acts as one
    send_packet(8'h04, 8'h10, 8'hF0);
    wait_idle();
    set_screen(8'd255, 8'd255);
    send_packet(8'h01, 8'h7F, 8'h80);
    send_packet(8'h03, 8'h7F, 8'h80);
    wait_idle();
    set_screen(8'd10, 8'd3);                // cursor now outside the screen
    send_packet(8'h00, 8'h00, 8'h00);
    wait_idle();

    // random phases, each with its own screen size
    for (int phase = 0; phase < 6; phase++) begin
      set_screen(pick_size(), pick_size());
      idle_on = (phase != 3);
      target  = (phase == 5) ? AUX_TARGET : aux_bytes + 140;
      while (aux_bytes < target) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_byte(8'($urandom), 1'b0);
        end else if (r < 12) begin
          send_byte(8'($urandom), 1'b1);    // stray byte shifts packet alignment
        end else begin
          send_packet(8'($urandom), pick_motion(), pick_motion());
        end
      end
      wait_idle();
      idle_on = 1'b1;
    end

    repeat (10) @(posedge clk);
    $display("tb: %0d aux bytes and %0d ignored bytes over %0d screen sizes",
             aux_bytes, ignored_bytes, screen_changes);
    $display("tb: %0d cursor updates compared, %0d mismatches", moves_checked, mismatches);
    if (mismatches == 0 && pending_moves == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
